FILE: rtl/round_robin_flow_queue_scheduler_top_defines.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef ROUND_ROBIN_FLOW_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_FLOW_QUEUE_SCHEDULER_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define RRFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies a property in the next.
`define RRFQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/rrfq_pkg.sv
package rrfq_pkg;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  flow_id;
    logic [31:0] msg_handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [3:0]  out_flow;
    logic [8:0]  total_queued;
  } out_word_t;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_PUSH_OK   = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [1:0] ST_POP_OK    = 2'd2;
  localparam logic [1:0] ST_POP_EMPTY = 2'd3;

endpackage

FILE: rtl/rrfq_ram.sv
module rrfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rrfq_pick.sv
// Cyclic find-first: first set bit of mask at or after start.
module rrfq_pick #(
  parameter int NUM_FLOWS = 16
) (
  input  logic [NUM_FLOWS-1:0]         mask,
  input  logic [$clog2(NUM_FLOWS)-1:0] start,
  output logic                         found,
  output logic [$clog2(NUM_FLOWS)-1:0] idx
);

  localparam int FW = $clog2(NUM_FLOWS);

  logic [NUM_FLOWS-1:0] hi;
  logic [NUM_FLOWS-1:0] src;

  always_comb begin
    hi    = mask & ~((NUM_FLOWS'(1) << start) - NUM_FLOWS'(1));
    src   = (|hi) ? hi : mask;
    found = |mask;
    idx   = '0;
    for (int i = NUM_FLOWS - 1; i >= 0; i--) begin
      if (src[i]) begin
        idx = FW'(i);
      end
    end
  end

endmodule

FILE: rtl/round_robin_flow_queue_scheduler_top.sv
// Round-robin flow queue scheduler.
// Input channel (in_valid / in_stall / in_data): one word per request, either
// a push of msg_handle onto flow flow_id or a pop of the next scheduled handle.
// Result channel (out_valid / out_stall / out_data): exactly one word per
// request, with status, delivered handle, flow and the total queued count.
// Each request passes accept, the per-flow head/count RAM read, then the
// result register load; a pop's handle comes from the store RAM read issued
// in the metadata read step. in_stall is high from accept until the result
// register load, so a new request is taken only after the previous one has
// passed both dependent RAM reads (flow metadata, then handle store).
// The result register is separate from the input side: a request is still
// accepted while an earlier result waits; it then holds in the load step
// until out_stall drops.
// Reset (rst_n low, synchronous) empties all flows and invalidates the
// round-robin pointer at once; the RAMs themselves are not cleared, since a
// per-flow active bit in flops marks which metadata entries mean anything.
`include "round_robin_flow_queue_scheduler_top_defines.svh"

module round_robin_flow_queue_scheduler_top
  import rrfq_pkg::*;
#(
  parameter int NUM_FLOWS    = 16,
  parameter int FLOW_DEPTH   = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int FW  = $clog2(NUM_FLOWS);
  localparam int HDW = $clog2(FLOW_DEPTH);
  localparam int CW  = $clog2(FLOW_DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int MW  = HDW + CW;
  localparam int SAW = $clog2(NUM_FLOWS * FLOW_DEPTH);
  localparam int TW  = $clog2(NUM_FLOWS * FLOW_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  // control state
  logic [1:0]           state_r, state_nxt;
  logic [NUM_FLOWS-1:0] active_r, active_nxt;
  logic                 rr_valid_r, rr_valid_nxt;
  logic [FW-1:0]        rr_ptr_r, rr_ptr_nxt;
  logic [TW-1:0]        total_r, total_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // request / result payload
  logic                    req_r;
  logic [3:0]              fid_r;
  logic [HANDLE_WIDTH-1:0] hdl_r;
  logic [FW-1:0]           f_r;
  logic                    miss_r;
  logic [1:0]              st_r, st_nxt;
  logic [3:0]              oflow_r, oflow_nxt;
  logic                    pop_ok_r, pop_ok_nxt;
  out_word_t               out_r;

  logic in_accept;
  logic out_load;

  // pickers
  logic          sel_found, nxt_found;
  logic [FW-1:0] sel_idx, nxt_idx;
  logic [FW-1:0] sel_start, nxt_start;
  logic [NUM_FLOWS-1:0] nxt_mask;

  // metadata RAM: {head, count} per flow
  logic          meta_we, meta_re;
  logic [FW-1:0] meta_raddr;
  logic [MW-1:0] meta_wdata, meta_rdata;

  // handle store RAM
  logic                    store_we, store_re;
  logic [SAW-1:0]          store_addr;
  logic [HANDLE_WIDTH-1:0] store_rdata;

  logic [HDW-1:0] head, head_inc;
  logic [CW-1:0]  cnt;
  logic [SW-1:0]  slot_sum;
  logic [HDW-1:0] slot;
  logic [SAW-1:0] flow_base;
  logic           push_ok, pop_ok;
  logic [7:0]     f_wide;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // select at accept: pointer flow if valid (always active), else lowest
  assign sel_start = rr_valid_r ? rr_ptr_r : '0;

  rrfq_pick #(.NUM_FLOWS(NUM_FLOWS)) u_pick_sel (
    .mask  (active_r),
    .start (sel_start),
    .found (sel_found),
    .idx   (sel_idx)
  );

  // next pointer: first active flow after the served one
  assign nxt_mask  = active_r & ~(NUM_FLOWS'(1) << f_r);
  assign nxt_start = (f_r == FW'(NUM_FLOWS - 1)) ? '0 : f_r + FW'(1);

  rrfq_pick #(.NUM_FLOWS(NUM_FLOWS)) u_pick_nxt (
    .mask  (nxt_mask),
    .start (nxt_start),
    .found (nxt_found),
    .idx   (nxt_idx)
  );

  assign meta_re    = in_accept;
  assign meta_raddr = (in_data.req_type == REQ_POP) ? sel_idx : FW'(in_data.flow_id);

  rrfq_ram #(.WIDTH(MW), .DEPTH(NUM_FLOWS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (f_r),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  rrfq_ram #(.WIDTH(HANDLE_WIDTH), .DEPTH(NUM_FLOWS * FLOW_DEPTH)) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (hdl_r),
    .re    (store_re),
    .raddr (store_addr),
    .rdata (store_rdata)
  );

  // metadata of an idle flow reads as empty, head restarting at zero
  always_comb begin
    head      = active_r[f_r] ? meta_rdata[MW-1:CW] : '0;
    cnt       = active_r[f_r] ? meta_rdata[CW-1:0] : '0;
    slot_sum  = SW'(head) + SW'(cnt);
    slot      = (slot_sum >= SW'(FLOW_DEPTH)) ? HDW'(slot_sum - SW'(FLOW_DEPTH))
                                              : HDW'(slot_sum);
    head_inc  = (head == HDW'(FLOW_DEPTH - 1)) ? '0 : head + HDW'(1);
    flow_base = SAW'(f_r) * SAW'(FLOW_DEPTH);
    push_ok   = (state_r == S_META) && (req_r == REQ_PUSH) && !miss_r
                && (cnt != CW'(FLOW_DEPTH));
    pop_ok    = (state_r == S_META) && (req_r == REQ_POP) && !miss_r;
    f_wide    = 8'(f_r);
  end

  always_comb begin
    store_we   = push_ok;
    store_re   = pop_ok;
    store_addr = flow_base + SAW'(pop_ok ? head : slot);
    meta_we    = push_ok || pop_ok;
    meta_wdata = pop_ok ? {head_inc, cnt - CW'(1)} : {head, cnt + CW'(1)};
  end

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    rr_valid_nxt  = rr_valid_r;
    rr_ptr_nxt    = rr_ptr_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    st_nxt        = st_r;
    oflow_nxt     = oflow_r;
    pop_ok_nxt    = pop_ok_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        state_nxt  = S_OUT;
        pop_ok_nxt = pop_ok;
        if (req_r == REQ_PUSH) begin
          oflow_nxt = fid_r;
          if (push_ok) begin
            st_nxt            = ST_PUSH_OK;
            active_nxt[f_r]   = 1'b1;
            total_nxt         = total_r + TW'(1);
          end else begin
            st_nxt = ST_PUSH_FULL;
          end
        end else if (pop_ok) begin
          st_nxt    = ST_POP_OK;
          oflow_nxt = f_wide[3:0];
          total_nxt = total_r - TW'(1);
          if (cnt == CW'(1)) begin
            active_nxt[f_r] = 1'b0;
          end
          rr_valid_nxt = nxt_found;
          if (nxt_found) begin
            rr_ptr_nxt = nxt_idx;
          end
        end else begin
          st_nxt       = ST_POP_EMPTY;
          oflow_nxt    = '0;
          rr_valid_nxt = 1'b0;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      rr_valid_r  <= 1'b0;
      rr_ptr_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      rr_valid_r  <= rr_valid_nxt;
      rr_ptr_r    <= rr_ptr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r  <= in_data.req_type;
      fid_r  <= in_data.flow_id;
      hdl_r  <= HANDLE_WIDTH'(in_data.msg_handle);
      f_r    <= meta_raddr;
      miss_r <= (in_data.req_type == REQ_POP)
                ? !sel_found
                : (32'(in_data.flow_id) >= 32'(NUM_FLOWS));
    end
    st_r     <= st_nxt;
    oflow_r  <= oflow_nxt;
    pop_ok_r <= pop_ok_nxt;
    if (out_load) begin
      out_r.status       <= st_r;
      out_r.out_handle   <= pop_ok_r ? 32'(store_rdata) : 32'd0;
      out_r.out_flow     <= oflow_r;
      out_r.total_queued <= 9'(total_r);
    end
  end

  // a valid pointer always names a flow with queued handles
  `RRFQ_ASSERT(a_ptr_active, !rr_valid_r || active_r[rr_ptr_r], "rr pointer on idle flow")
  // no active flow exactly when nothing is queued
  `RRFQ_ASSERT(a_total_active, (active_r == '0) == (total_r == '0), "active map vs total")
  // an accepted request always goes to the metadata step
  `RRFQ_ASSERT_NEXT(a_accept_meta, in_accept, state_r == S_META, "accept without meta read")
  // a new result only comes out of the load step
  `RRFQ_ASSERT_NEXT(a_load_valid, out_load, out_valid_r && (state_r == S_IDLE), "result load lost")

endmodule
